// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers for the coherence controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
	else $error("%m: assertion failed");

// Condition in one cycle implies a consequence in the next one.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
	else $error("%m: assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== hdl/mlcc_pkg.sv =====
`default_nettype none

package mlcc_pkg;

	localparam int ADDR_BITS = 32;
	localparam int ID_BITS   = 4;

	typedef enum logic [3:0] {
		ST_I   = 4'd0,
		ST_ISE = 4'd1,
		ST_IM  = 4'd2,
		ST_SM  = 4'd3,
		ST_OM  = 4'd4,
		ST_S   = 4'd5,
		ST_E   = 4'd6,
		ST_M   = 4'd7,
		ST_O   = 4'd8
	} line_state_t;

	typedef enum logic [2:0] {
		CMD_LOAD  = 3'd0,
		CMD_STORE = 3'd1,
		CMD_GETS  = 3'd2,
		CMD_GETM  = 3'd3,
		CMD_DATA  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic        issue_gets;
		logic        issue_getm;
		logic        reply;
		logic        supply;
		logic        assert_shared;
		logic        miss;
		logic        silent;
		logic        error;
		line_state_t next_state;
	} coh_result_t;

endpackage

`default_nettype wire

// ===== hdl/mlcc_decode.sv =====
`default_nettype none

module mlcc_decode import mlcc_pkg::*; (
	input  line_state_t        state,
	input  logic [2:0]         command,
	input  logic [ID_BITS-1:0] requester_id,
	input  logic [ID_BITS-1:0] own_id,
	input  logic               shared_sampled,
	output coh_result_t        result
);

	coh_result_t r;
	cmd_t        cmd;

	assign cmd = cmd_t'(command);

	always_comb begin
		r            = '0;
		r.next_state = state;
		unique case (state)
			ST_I: begin
				case (cmd)
					CMD_LOAD: begin
						r.issue_gets = 1'b1;
						r.miss       = 1'b1;
						r.next_state = ST_ISE;
					end
					CMD_STORE: begin
						r.issue_getm = 1'b1;
						r.miss       = 1'b1;
						r.next_state = ST_IM;
					end
					CMD_GETS, CMD_GETM, CMD_DATA: ;
					default: r.error = 1'b1;
				endcase
			end
			ST_S: begin
				case (cmd)
					CMD_LOAD: begin
						r.assert_shared = 1'b1;
						r.reply         = 1'b1;
					end
					CMD_STORE: begin
						r.issue_getm = 1'b1;
						r.miss       = 1'b1;
						r.next_state = ST_SM;
					end
					CMD_GETS: r.assert_shared = 1'b1;
					CMD_GETM: r.next_state = ST_I;
					default:  r.error = 1'b1;
				endcase
			end
			ST_E: begin
				case (cmd)
					CMD_LOAD: r.reply = 1'b1;
					CMD_STORE: begin
						r.reply      = 1'b1;
						r.silent     = 1'b1;
						r.next_state = ST_M;
					end
					CMD_GETS: begin
						r.assert_shared = 1'b1;
						r.supply        = 1'b1;
						r.next_state    = ST_S;
					end
					CMD_GETM: begin
						r.supply     = 1'b1;
						r.next_state = ST_I;
					end
					default: r.error = 1'b1;
				endcase
			end
			ST_O: begin
				case (cmd)
					CMD_LOAD: r.reply = 1'b1;
					CMD_STORE: begin
						r.issue_getm = 1'b1;
						r.miss       = 1'b1;
						r.next_state = ST_OM;
					end
					// owner keeps the shared line up so the requester cannot go exclusive
					CMD_GETS: begin
						r.assert_shared = 1'b1;
						r.supply        = 1'b1;
					end
					CMD_GETM: begin
						r.supply     = 1'b1;
						r.next_state = ST_I;
					end
					default: r.error = 1'b1;
				endcase
			end
			ST_M: begin
				case (cmd)
					CMD_LOAD, CMD_STORE: r.reply = 1'b1;
					CMD_GETS: begin
						r.assert_shared = 1'b1;
						r.supply        = 1'b1;
						r.next_state    = ST_O;
					end
					CMD_GETM: begin
						r.supply     = 1'b1;
						r.next_state = ST_I;
					end
					default: r.error = 1'b1;
				endcase
			end
			ST_ISE: begin
				case (cmd)
					CMD_GETS, CMD_GETM: ;
					CMD_DATA: begin
						r.reply      = 1'b1;
						r.next_state = shared_sampled ? ST_S : ST_E;
					end
					default: r.error = 1'b1;
				endcase
			end
			ST_IM: begin
				case (cmd)
					CMD_GETS, CMD_GETM: ;
					CMD_DATA: begin
						r.reply      = 1'b1;
						r.next_state = ST_M;
					end
					default: r.error = 1'b1;
				endcase
			end
			ST_SM: begin
				case (cmd)
					CMD_GETS: r.assert_shared = 1'b1;
					CMD_GETM: r.next_state = ST_IM;
					CMD_DATA: begin
						r.reply      = 1'b1;
						r.next_state = ST_M;
					end
					default: r.error = 1'b1;
				endcase
			end
			ST_OM: begin
				case (cmd)
					CMD_GETS: begin
						r.assert_shared = 1'b1;
						r.supply        = 1'b1;
					end
					// our own GETM seen on the bus leaves the line in OM
					CMD_GETM: begin
						r.assert_shared = 1'b1;
						r.supply        = 1'b1;
						if (requester_id != own_id) begin
							r.next_state = ST_IM;
						end
					end
					CMD_DATA: begin
						r.reply      = 1'b1;
						r.next_state = ST_M;
					end
					default: r.error = 1'b1;
				endcase
			end
			default: r.error = 1'b1;
		endcase

		// drop every action on an illegal combination, keep the state
		if (r.error) begin
			r            = '0;
			r.error      = 1'b1;
			r.next_state = state;
		end
	end

	assign result = r;

endmodule

`default_nettype wire

// ===== hdl/moesi_line_coherence_controller.sv =====
`default_nettype none
// Channel   Handshake                 Payload
// input     in_valid / in_stall       command, line_address, requester_id, shared_sampled
// output    out_valid / out_stall     issue_gets ... new_line_state
// config    cfg_write_en              cfg_write_data (own_module_id)
//
// One item per cycle sustained while out_stall is low; an item passes through the
// input register, then state decode into the result register.
// The line state updates as an item leaves the input register, so successive items chain.
// arst_n clears the line state to I, own_module_id to 0 and both valid flags.
// A stalled result holds the input register; in_stall rises only when both stages are full.
`include "assert_macros.svh"

module moesi_line_coherence_controller import mlcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write_en,
	input  logic [ID_BITS-1:0]   cfg_write_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           command,
	input  logic [ADDR_BITS-1:0] line_address,
	input  logic [ID_BITS-1:0]   requester_id,
	input  logic                 shared_sampled,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 issue_gets,
	output logic                 issue_getm,
	output logic                 reply_to_processor,
	output logic                 supply_on_bus,
	output logic [ID_BITS-1:0]   supply_target,
	output logic [ADDR_BITS-1:0] out_address,
	output logic                 assert_shared,
	output logic                 miss_event,
	output logic                 silent_upgrade_event,
	output logic                 protocol_error,
	output logic [3:0]           new_line_state
);

	logic [ID_BITS-1:0]   own_id_q;
	line_state_t          line_state_q;

	logic                 valid_s1;
	logic [2:0]           command_s1;
	logic [ADDR_BITS-1:0] address_s1;
	logic [ID_BITS-1:0]   requester_s1;
	logic                 shared_s1;

	logic                 out_valid_q;
	coh_result_t          res_q;
	logic [ID_BITS-1:0]   target_q;
	logic [ADDR_BITS-1:0] address_q;

	coh_result_t          res;
	logic                 adv_s1;
	logic                 take_in;

	mlcc_decode u_decode (
		.state          (line_state_q),
		.command        (command_s1),
		.requester_id   (requester_s1),
		.own_id         (own_id_q),
		.shared_sampled (shared_s1),
		.result         (res)
	);

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= '0;
			line_state_q <= ST_I;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				own_id_q <= cfg_write_data;
			end
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q  <= 1'b1;
				line_state_q <= res.next_state;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			command_s1   <= command;
			address_s1   <= line_address;
			requester_s1 <= requester_id;
			shared_s1    <= shared_sampled;
		end
		if (adv_s1) begin
			res_q     <= res;
			target_q  <= res.supply ? requester_s1 : '0;
			address_q <= (res.issue_gets || res.issue_getm || res.reply || res.supply) ?
				address_s1 : '0;
		end
	end

	assign out_valid            = out_valid_q;
	assign issue_gets           = res_q.issue_gets;
	assign issue_getm           = res_q.issue_getm;
	assign reply_to_processor   = res_q.reply;
	assign supply_on_bus        = res_q.supply;
	assign supply_target        = target_q;
	assign out_address          = address_q;
	assign assert_shared        = res_q.assert_shared;
	assign miss_event           = res_q.miss;
	assign silent_upgrade_event = res_q.silent;
	assign protocol_error       = res_q.error;
	assign new_line_state       = res_q.next_state;

	`ASSERT_NEXT(a_err_keeps_state, clk, arst_n, adv_s1 && res.error, $stable(line_state_q))
	`ASSERT_NEXT(a_result_tracks_state, clk, arst_n, adv_s1, out_valid_q && (new_line_state == line_state_q))
	`ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(address_s1))
	`ASSERT_IMPL(a_no_take_when_full, clk, arst_n, valid_s1 && out_valid_q && out_stall, in_stall)

endmodule

`default_nettype wire
